>>> rtl/pfbt_pkg.sv
// Package for the paging frame budget table: widths, codes, FSM state type and
// the small control structs passed between the sequencer, divider and table.
// No dependencies.
package pfbt_pkg;

    localparam int ID_W    = 16;
    localparam int SIZE_W  = 24;
    localparam int FRAME_W = 16;
    localparam int STAT_W  = 3;
    localparam int NEED_W  = SIZE_W + 1;
    localparam int CFG_W   = 1;

    // operation codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_FRAME_SIZE   = 1'b0;
    localparam logic [CFG_W-1:0] CFG_TOTAL_FRAMES = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EXISTS     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MEM_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_TAIL,
        S_DECIDE,
        S_DIV,
        S_EVAL,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } tbl_cmd_t;

endpackage

>>> rtl/pfbt_div.sv
// Radix-2 restoring divider returning ceil(dividend / divisor), one quotient
// bit per cycle. Depends on pfbt_pkg.
module pfbt_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pfbt_pkg::SIZE_W-1:0]    dividend,
    input  logic [pfbt_pkg::FRAME_W-1:0]   divisor,
    output pfbt_pkg::div_status_t          stat,
    output logic [pfbt_pkg::NEED_W-1:0]    ceil_q
);

    localparam int SW    = pfbt_pkg::SIZE_W;
    localparam int FW    = pfbt_pkg::FRAME_W;
    localparam int NW    = pfbt_pkg::NEED_W;
    localparam int CNT_W = $clog2(SW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SW-1:0]    quo_reg;
    logic [FW-1:0]    rem_reg;
    logic [FW-1:0]    dsr_reg;

    logic [FW:0]      shifted;
    logic [FW:0]      diff;
    logic             fits;
    logic [FW-1:0]    rem_next;
    logic [SW-1:0]    quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SW-1]};
        fits     = (shifted >= {1'b0, dsr_reg});
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = fits ? diff[FW-1:0] : shifted[FW-1:0];
        quo_next = {quo_reg[SW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // round up when anything is left over
    assign ceil_q    = {1'b0, quo_reg} + NW'(rem_reg != '0);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/pfbt_table.sv
// Process table storage: valid bits in flops, ids and sizes in a memory with
// one write port and one registered read port. Depends on pfbt_pkg.
module pfbt_table
#(
    parameter int ENTRIES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [$clog2(ENTRIES)-1:0]        rd_addr,
    output logic [pfbt_pkg::ID_W-1:0]         rd_id,
    output logic [pfbt_pkg::SIZE_W-1:0]       rd_size,
    output logic                              rd_valid,
    input  pfbt_pkg::tbl_cmd_t                cmd,
    input  logic [$clog2(ENTRIES)-1:0]        wr_addr,
    input  logic [pfbt_pkg::ID_W-1:0]         wr_id,
    input  logic [pfbt_pkg::SIZE_W-1:0]       wr_size
);

    logic [ENTRIES-1:0]               valid_reg;
    logic [pfbt_pkg::ID_W-1:0]        id_mem   [ENTRIES];
    logic [pfbt_pkg::SIZE_W-1:0]      size_mem [ENTRIES];
    logic [pfbt_pkg::ID_W-1:0]        rd_id_reg;
    logic [pfbt_pkg::SIZE_W-1:0]      rd_size_reg;
    logic                             rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (cmd.remove)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            id_mem[wr_addr]   <= wr_id;
            size_mem[wr_addr] <= wr_size;
        end
        if (rd_en)
        begin
            rd_id_reg   <= id_mem[rd_addr];
            rd_size_reg <= size_mem[rd_addr];
        end
    end

    assign rd_id    = rd_id_reg;
    assign rd_size  = rd_size_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> rtl/paging_frame_budget_table.sv
// Paging frame budget table top level: sequencer, config registers, result
// register. Depends on pfbt_pkg, pfbt_div and pfbt_table.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, operation, process_id,      | sink
//          | process_size                                    |
//  out     | out_valid, out_ready, status, frames_left,      | source
//          | removed_size                                    |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | sink
//
// An item that fails the lookup goes from idle through the scan, the scan tail and
// the decision straight to finish; any other item also divides and evaluates:
// one table read per cycle through the memory port, then 24 steps of the shared
// divider, whose done flag moves the sequencer on to evaluation.
// in_ready is high only in idle; the result register lets the next beat in
// while a result waits, and a finished item holds until that register frees.
// Reset clears the valid bits at once; no clearing pass. cfg_ready is always high.
module paging_frame_budget_table
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [pfbt_pkg::ID_W-1:0]         process_id,
    input  logic [pfbt_pkg::SIZE_W-1:0]       process_size,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pfbt_pkg::STAT_W-1:0]       status,
    output logic [pfbt_pkg::FRAME_W-1:0]      frames_left,
    output logic [pfbt_pkg::SIZE_W-1:0]       removed_size,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfbt_pkg::CFG_W-1:0]        cfg_index,
    input  logic [pfbt_pkg::FRAME_W-1:0]      cfg_data
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int IW  = pfbt_pkg::ID_W;
    localparam int SW  = pfbt_pkg::SIZE_W;
    localparam int FW  = pfbt_pkg::FRAME_W;
    localparam int NW  = pfbt_pkg::NEED_W;
    localparam int TW  = pfbt_pkg::STAT_W;
    localparam logic [AW-1:0] IDX_LAST = AW'(TABLE_ENTRIES - 1);

    pfbt_pkg::fsm_state_t state_reg, state_next;

    logic            op_reg,        op_next;
    logic [IW-1:0]   id_reg,        id_next;
    logic [SW-1:0]   size_reg,      size_next;
    logic [FW-1:0]   fsize_reg;
    logic [FW-1:0]   total_reg;
    logic [FW-1:0]   used_reg,      used_next;
    logic [AW-1:0]   scan_idx_reg,  scan_idx_next;
    logic [AW-1:0]   cmp_idx_reg;
    logic            cmp_live_reg;
    logic            found_reg,     found_next;
    logic [AW-1:0]   found_idx_reg, found_idx_next;
    logic [SW-1:0]   found_size_reg, found_size_next;
    logic            free_found_reg, free_found_next;
    logic [AW-1:0]   free_idx_reg,  free_idx_next;
    logic [TW-1:0]   status_reg,    status_next;
    logic [SW-1:0]   removed_reg,   removed_next;
    logic            out_valid_reg;
    logic [TW-1:0]   out_status_reg;
    logic [FW-1:0]   out_left_reg;
    logic [SW-1:0]   out_removed_reg;

    // sequencer outputs
    logic                     in_accept;
    logic                     tbl_rd_en;
    logic                     div_start;
    logic                     out_load;
    pfbt_pkg::tbl_cmd_t       tbl_cmd;
    logic [AW-1:0]            tbl_wr_addr;

    logic [IW-1:0]            tbl_rd_id;
    logic [SW-1:0]            tbl_rd_size;
    logic                     tbl_rd_valid;
    pfbt_pkg::div_status_t    div_stat;
    logic [NW-1:0]            need;
    logic [SW-1:0]            div_dividend;
    logic [FW-1:0]            div_divisor;
    logic [FW-1:0]            free_frames;
    logic                     hit;
    logic                     empty_slot;
    logic                     slot_free;
    logic                     add_ok;

    assign free_frames = (total_reg > used_reg) ? (total_reg - used_reg) : '0;
    assign hit         = cmp_live_reg && tbl_rd_valid && (tbl_rd_id == id_reg);
    assign empty_slot  = cmp_live_reg && !tbl_rd_valid;
    assign slot_free   = !out_valid_reg || out_ready;
    assign add_ok      = (need <= {{(NW - FW){1'b0}}, free_frames}) && free_found_reg;
    assign div_divisor = (fsize_reg == '0) ? FW'(1) : fsize_reg;
    assign div_dividend = (op_reg == pfbt_pkg::OP_ADD) ? size_reg : found_size_reg;

    pfbt_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_addr  (scan_idx_reg),
        .rd_id    (tbl_rd_id),
        .rd_size  (tbl_rd_size),
        .rd_valid (tbl_rd_valid),
        .cmd      (tbl_cmd),
        .wr_addr  (tbl_wr_addr),
        .wr_id    (id_reg),
        .wr_size  (size_reg)
    );

    pfbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .ceil_q   (need)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfbt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pfbt_pkg::S_SCAN;
                end
            end
            pfbt_pkg::S_SCAN:
            begin
                if (scan_idx_reg == IDX_LAST)
                begin
                    state_next = pfbt_pkg::S_SCAN_TAIL;
                end
            end
            pfbt_pkg::S_SCAN_TAIL:
            begin
                state_next = pfbt_pkg::S_DECIDE;
            end
            pfbt_pkg::S_DECIDE:
            begin
                if ((op_reg == pfbt_pkg::OP_ADD) == found_reg)
                begin
                    state_next = pfbt_pkg::S_FINISH;
                end
                else
                begin
                    state_next = pfbt_pkg::S_DIV;
                end
            end
            pfbt_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = pfbt_pkg::S_EVAL;
                end
            end
            pfbt_pkg::S_EVAL:
            begin
                state_next = pfbt_pkg::S_FINISH;
            end
            pfbt_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = pfbt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfbt_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        tbl_rd_en   = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        tbl_cmd     = '0;
        tbl_wr_addr = (op_reg == pfbt_pkg::OP_ADD) ? free_idx_reg : found_idx_reg;
        unique case (state_reg)
            pfbt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            pfbt_pkg::S_SCAN:
            begin
                tbl_rd_en = 1'b1;
            end
            pfbt_pkg::S_DECIDE:
            begin
                div_start = ((op_reg == pfbt_pkg::OP_ADD) != found_reg);
            end
            pfbt_pkg::S_EVAL:
            begin
                if (op_reg == pfbt_pkg::OP_ADD)
                begin
                    tbl_cmd.insert = add_ok;
                end
                else
                begin
                    tbl_cmd.remove = 1'b1;
                end
            end
            pfbt_pkg::S_FINISH:
            begin
                out_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_accept = in_valid && in_ready;

    // datapath next values
    always_comb
    begin
        op_next         = op_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        used_next       = used_reg;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_size_next = found_size_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        removed_next    = removed_reg;

        if (in_accept)
        begin
            op_next         = operation;
            id_next         = process_id;
            size_next       = process_size;
            scan_idx_next   = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            removed_next    = '0;
        end

        if (state_reg == pfbt_pkg::S_SCAN && scan_idx_reg != IDX_LAST)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        // keep the lowest matching slot and the lowest empty slot
        if (hit && !found_reg)
        begin
            found_next      = 1'b1;
            found_idx_next  = cmp_idx_reg;
            found_size_next = tbl_rd_size;
        end
        if (empty_slot && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_idx_next   = cmp_idx_reg;
        end

        if (state_reg == pfbt_pkg::S_DECIDE)
        begin
            if (op_reg == pfbt_pkg::OP_ADD)
            begin
                status_next = pfbt_pkg::STAT_EXISTS;
            end
            else
            begin
                status_next = pfbt_pkg::STAT_NOT_FOUND;
            end
        end

        if (state_reg == pfbt_pkg::S_EVAL)
        begin
            if (op_reg == pfbt_pkg::OP_ADD)
            begin
                if (need > {{(NW - FW){1'b0}}, free_frames})
                begin
                    status_next = pfbt_pkg::STAT_MEM_FULL;
                end
                else if (!free_found_reg)
                begin
                    status_next = pfbt_pkg::STAT_TABLE_FULL;
                end
                else
                begin
                    status_next = pfbt_pkg::STAT_OK;
                    used_next   = used_reg + need[FW-1:0];
                end
            end
            else
            begin
                status_next  = pfbt_pkg::STAT_OK;
                removed_next = found_size_reg;
                // saturate at zero if frame size changed since the add
                if (need >= {{(NW - FW){1'b0}}, used_reg})
                begin
                    used_next = '0;
                end
                else
                begin
                    used_next = used_reg - need[FW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pfbt_pkg::S_IDLE;
            fsize_reg      <= FW'(1);
            total_reg      <= '0;
            used_reg       <= '0;
            cmp_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            cmp_live_reg   <= tbl_rd_en;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pfbt_pkg::CFG_FRAME_SIZE:   fsize_reg <= cfg_data;
                    pfbt_pkg::CFG_TOTAL_FRAMES: total_reg <= cfg_data;
                    default:                    total_reg <= total_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        size_reg       <= size_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= scan_idx_reg;
        found_idx_reg  <= found_idx_next;
        found_size_reg <= found_size_next;
        free_idx_reg   <= free_idx_next;
        status_reg     <= status_next;
        removed_reg    <= removed_next;
        if (out_load)
        begin
            out_status_reg  <= status_reg;
            out_left_reg    <= free_frames;
            out_removed_reg <= removed_reg;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign frames_left  = out_left_reg;
    assign removed_size = out_removed_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == pfbt_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.insert |-> free_found_reg && !found_reg)
        else $error("insert without a free slot or with a duplicate id");

    a_remove_has_match: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.remove |-> found_reg && op_reg == pfbt_pkg::OP_DEL)
        else $error("remove without a matching entry");

    a_removed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_removed_reg != '0 |-> out_status_reg == pfbt_pkg::STAT_OK)
        else $error("nonzero removed size on a failed operation");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == pfbt_pkg::S_SCAN && scan_idx_reg == '0)
        else $error("accepted beat did not start a table scan");

endmodule

>>> tb/sv/paging_frame_budget_table_checker.sv
// Checker for the paging frame budget table: watches the request, result and
// register channels, tracks its own copy of the process table and frame count,
// and compares every result beat. Depends on pfbt_pkg.
module paging_frame_budget_table_checker
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              operation,
    input  logic [pfbt_pkg::ID_W-1:0]         process_id,
    input  logic [pfbt_pkg::SIZE_W-1:0]       process_size,

    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [pfbt_pkg::STAT_W-1:0]       status,
    input  logic [pfbt_pkg::FRAME_W-1:0]      frames_left,
    input  logic [pfbt_pkg::SIZE_W-1:0]       removed_size,

    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [pfbt_pkg::CFG_W-1:0]        cfg_index,
    input  logic [pfbt_pkg::FRAME_W-1:0]      cfg_data,

    output int                                mismatches,
    output int                                outstanding
);

    import pfbt_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] frames_left;
        logic [SIZE_W-1:0]  removed_size;
    } budget_result_t;

    budget_result_t     awaited_results[$];

    logic [FRAME_W-1:0] frame_bytes  = 16'd1;
    logic [FRAME_W-1:0] frames_total = '0;
    logic [FRAME_W-1:0] frames_taken = '0;
    logic               slot_live [TABLE_ENTRIES];
    logic [ID_W-1:0]    slot_id   [TABLE_ENTRIES];
    logic [SIZE_W-1:0]  slot_size [TABLE_ENTRIES];
    int                 error_total = 0;

    function automatic void clear_table();
        frame_bytes  = 16'd1;
        frames_total = '0;
        frames_taken = '0;
        foreach (slot_live[i])
            slot_live[i] = 1'b0;
    endfunction

    // round up; a zero frame size counts as one byte
    function automatic logic [NEED_W-1:0] frames_for(input logic [SIZE_W-1:0] bytes);
        logic [NEED_W-1:0] unit;
        unit = (frame_bytes == '0) ? NEED_W'(1) : NEED_W'(frame_bytes);
        return (NEED_W'(bytes) + unit - NEED_W'(1)) / unit;
    endfunction

    function automatic logic [FRAME_W-1:0] frames_free();
        return (frames_total > frames_taken) ? frames_total - frames_taken : '0;
    endfunction

    function automatic int find_process(input logic [ID_W-1:0] pid);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_live[i] && slot_id[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic int open_slot();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!slot_live[i])
                return i;
        return -1;
    endfunction

    function automatic budget_result_t apply_request(input logic op,
                                                     input logic [ID_W-1:0] pid,
                                                     input logic [SIZE_W-1:0] bytes);
        budget_result_t    res;
        logic [NEED_W-1:0] need;
        int                slot;
        res        = '0;
        res.status = STAT_OK;
        if (op == OP_ADD)
        begin
            need = frames_for(bytes);
            slot = open_slot();
            // duplicate id wins over memory, memory wins over table space
            if (find_process(pid) >= 0)
                res.status = STAT_EXISTS;
            else if (need > NEED_W'(frames_free()))
                res.status = STAT_MEM_FULL;
            else if (slot < 0)
                res.status = STAT_TABLE_FULL;
            else
            begin
                slot_live[slot] = 1'b1;
                slot_id[slot]   = pid;
                slot_size[slot] = bytes;
                frames_taken    = frames_taken + FRAME_W'(need);
            end
        end
        else
        begin
            slot = find_process(pid);
            if (slot < 0)
                res.status = STAT_NOT_FOUND;
            else
            begin
                // refund at the current frame size, floor at zero
                need             = frames_for(slot_size[slot]);
                res.removed_size = slot_size[slot];
                frames_taken     = (need >= NEED_W'(frames_taken)) ?
                                   '0 : frames_taken - FRAME_W'(need);
                slot_live[slot]  = 1'b0;
            end
        end
        res.frames_left = frames_free();
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: result mismatch: %s", $time, what);
        error_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        budget_result_t got;
        budget_result_t want;
        if (!rst_n)
        begin
            clear_table();
            awaited_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FRAME_SIZE)
                    frame_bytes = cfg_data;
                else
                    frames_total = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                got = {status, frames_left, removed_size};
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("unexpected beat, status %0d", got.status));
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.frames_left !== want.frames_left)
                        report_mismatch($sformatf("frames_left %0d, want %0d",
                                                  got.frames_left, want.frames_left));
                    if (got.removed_size !== want.removed_size)
                        report_mismatch($sformatf("removed_size %0d, want %0d",
                                                  got.removed_size, want.removed_size));
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_request(operation, process_id, process_size));
        end
        mismatches  <= error_total;
        outstanding <= awaited_results.size();
    end

endmodule

>>> tb/sv/paging_frame_budget_table_tb.sv
// Testbench top for the paging frame budget table: clock, reset, request and
// register stimulus, result back-pressure and the verdict. Depends on pfbt_pkg,
// paging_frame_budget_table and paging_frame_budget_table_checker.
module paging_frame_budget_table_tb;

    import pfbt_pkg::*;

    localparam int TABLE_ENTRIES = 16;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                operation    = OP_ADD;
    logic [ID_W-1:0]     process_id   = '0;
    logic [SIZE_W-1:0]   process_size = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [FRAME_W-1:0]  frames_left;
    logic [SIZE_W-1:0]   removed_size;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_index    = CFG_FRAME_SIZE;
    logic [FRAME_W-1:0]  cfg_data     = '0;
    int                  mismatches;
    int                  outstanding;
    int                  idle_pct     = 36;

    paging_frame_budget_table
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .process_id   (process_id),
        .process_size (process_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .frames_left  (frames_left),
        .removed_size (removed_size),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    paging_frame_budget_table_checker
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .process_id   (process_id),
        .process_size (process_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .frames_left  (frames_left),
        .removed_size (removed_size),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // stall the result side at random
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= idle_pct);

    // hold valid from the last beat when no gap is taken
    task automatic push_request(input logic op,
                                input logic [ID_W-1:0] pid,
                                input logic [SIZE_W-1:0] bytes);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        process_id   <= pid;
        process_size <= bytes;
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid, drain every result, then write both registers
    task automatic reconfigure(input logic [FRAME_W-1:0] fs,
                               input logic [FRAME_W-1:0] total);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || !in_ready);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_SIZE;
        cfg_data  <= fs;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_TOTAL_FRAMES;
        cfg_data  <= total;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                unit;
        int                total;
        int                fs;
        int                k;
        int                add_pct;
        int                base;
        logic [ID_W-1:0]   pid;
        logic [SIZE_W-1:0] bytes;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: one-byte frames and no memory, so only empty processes fit
        push_request(OP_ADD, 16'd0, 24'd0);
        push_request(OP_ADD, 16'd0, 24'd0);
        push_request(OP_ADD, 16'd1, 24'd1);
        push_request(OP_DEL, 16'd0, 24'hFFFFFF);
        push_request(OP_DEL, 16'd0, 24'd0);

        // zero frame size acts as one byte
        reconfigure(16'd0, 16'hFFFF);
        push_request(OP_ADD, 16'hFFFF, 24'hFFFFFF);
        push_request(OP_ADD, 16'hFFFF, 24'd65535);
        push_request(OP_DEL, 16'hFFFF, 24'd0);

        reconfigure(16'hFFFF, 16'd3);
        push_request(OP_ADD, 16'd10, 24'd65536);
        push_request(OP_ADD, 16'd11, 24'd65535);
        push_request(OP_ADD, 16'd13, 24'd0);

        // total dropped below the frames in use
        reconfigure(16'hFFFF, 16'd1);
        push_request(OP_ADD, 16'd14, 24'd0);
        push_request(OP_DEL, 16'd11, 24'd0);

        // shrink the frame size so the refund exceeds the frames in use
        reconfigure(16'd1, 16'hFFFF);
        push_request(OP_DEL, 16'd10, 24'd0);

        // fill the table, then hit each rejection on a full table
        for (int i = 0; i < TABLE_ENTRIES - 2; i++)
            push_request(OP_ADD, ID_W'(100 + i), 24'd0);
        push_request(OP_ADD, 16'd200, 24'd0);
        push_request(OP_ADD, 16'd200, 24'd70000);
        push_request(OP_ADD, 16'd13, 24'd0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    fs    = 1;
                    total = 65535;
                end
                1:
                begin
                    fs    = 65535;
                    total = $urandom_range(0, 40);
                end
                2:
                begin
                    fs    = 0;
                    total = $urandom_range(0, 400);
                end
                3:
                begin
                    fs    = $urandom_range(1, 65535);
                    total = $urandom_range(0, 65535);
                end
                4:
                begin
                    fs    = $urandom_range(1, 512);
                    total = $urandom_range(0, 5);
                end
                default:
                begin
                    fs    = $urandom_range(0, 65535);
                    total = $urandom_range(16, 4000);
                end
            endcase
            idle_pct = (phase == 3) ? 0 : 36;
            add_pct  = 55 + 5 * phase;
            base     = $urandom_range(0, 65535);
            unit     = (fs == 0) ? 1 : fs;
            reconfigure(FRAME_W'(fs), FRAME_W'(total));
            for (int n = 0; n < 125; n++)
            begin
                // small id pool so adds collide and deletes hit
                pid = ID_W'(base + $urandom_range(0, 19));
                if ($urandom_range(0, 99) < 5)
                    pid = ID_W'($urandom_range(0, 65535));
                case ($urandom_range(0, 9))
                    0:       bytes = '0;
                    1:       bytes = SIZE_W'($urandom);
                    default:
                    begin
                        k     = $urandom_range(0, total / 8 + 2);
                        bytes = SIZE_W'(k * unit + $urandom_range(0, 2) - 1);
                    end
                endcase
                push_request(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DEL, pid, bytes);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
